// ===== design/tle_pkg.sv =====
`timescale 1ns / 1ps

package tle_pkg;

  localparam int LINE_CAPACITY_DEF = 32;

  typedef logic [6:0] char_t;

  localparam char_t BELL  = 7'h07;
  localparam char_t SPACE = 7'h20;
  localparam char_t NUL   = 7'h00;

  localparam logic [7:0] CH_EOT      = 8'd4;
  localparam logic [7:0] CH_BS       = 8'd8;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_RIGHT    = 8'd14;
  localparam logic [7:0] CH_LEFT     = 8'd15;
  localparam logic [7:0] CH_CAN      = 8'd25;
  localparam logic [7:0] CH_PRINT_LO = 8'd32;
  localparam logic [7:0] CH_DEL      = 8'd127;

  localparam int NUM_CMDS = 5;
  localparam int CMD_SPAN = 7;

  // command strings, null terminated
  localparam char_t CMD_TEXT [NUM_CMDS][CMD_SPAN] = '{
    '{7'h63, 7'h6c, 7'h65, 7'h61, 7'h72, 7'h00, 7'h00},
    '{7'h65, 7'h78, 7'h69, 7'h74, 7'h00, 7'h00, 7'h00},
    '{7'h74, 7'h72, 7'h61, 7'h69, 7'h6e, 7'h21, 7'h00},
    '{7'h77, 7'h72, 7'h69, 7'h74, 7'h65, 7'h00, 7'h00},
    '{7'h72, 7'h65, 7'h61, 7'h64, 7'h00, 7'h00, 7'h00}
  };

  localparam logic [2:0] CMD_LEN [NUM_CMDS] = '{3'd5, 3'd4, 3'd6, 3'd5, 3'd4};

  localparam logic [2:0] SCAN_LAST = 3'd6;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_EOT,
    EV_CANCEL,
    EV_COMMAND
  } line_event_t;

  typedef enum logic [2:0] {
    CMD_INVALID,
    CMD_CLEAR,
    CMD_EXIT,
    CMD_TRAIN,
    CMD_WRITE,
    CMD_READ
  } cmd_code_t;

endpackage

// ===== design/tle_in_if.sv =====
`timescale 1ns / 1ps

interface tle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/tle_out_if.sv =====
`timescale 1ns / 1ps

interface tle_out_if;
  logic       valid;
  logic       ready;
  logic       echo_valid;
  logic [6:0] echo_byte;
  logic [1:0] line_event;
  logic [2:0] command_code;

  modport source (output valid, output echo_valid, output echo_byte,
                  output line_event, output command_code, input ready);
  modport sink (input valid, input echo_valid, input echo_byte,
                input line_event, input command_code, output ready);
endinterface

// ===== design/terminal_line_editor_command_matcher.sv =====
`timescale 1ns / 1ps

// Terminal line editor with command matcher.
// in_ch carries one received terminal byte per beat; out_ch returns exactly
// one result beat per input beat: echo flag and byte, line event, command.
// Editing bytes (printable, backspace, delete, cursor moves, EOT, cancel,
// ignored controls) have a registered result that shows on out_ch the cycle
// after the input beat, and a new byte can be taken every cycle while out_ch
// keeps taking results.
// Carriage return reads the first seven line entries one per cycle from the
// line store and matches them against the command table; its result is
// registered after the scan, drain and finish states, and the line is cleared.
// in_ch.ready is low while a carriage return is being matched, and while a
// result waits on out_ch with out_ch.ready low; a stalled result holds.
// Reset (rst_n low, synchronous) empties the line at once: cursor, length
// and all entry valid bits are cleared, so no clearing pass is needed.

module terminal_line_editor_command_matcher
  import tle_pkg::*;
#(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tle_in_if.sink     in_ch,
  tle_out_if.source  out_ch
);

  localparam int AW = $clog2(LINE_CAPACITY);
  localparam int CW = $clog2(LINE_CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  state_t      state_r, state_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [2:0]  scan_idx_r, scan_idx_nxt;
  logic        step_r, step_nxt;
  logic [2:0]  step_idx_r, step_idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        echo_valid_r, echo_valid_nxt;
  char_t       echo_byte_r, echo_byte_nxt;
  line_event_t line_event_r, line_event_nxt;
  cmd_code_t   command_code_r, command_code_nxt;

  logic          in_ready;
  logic          accept;
  logic          clr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  char_t         wr_data;
  char_t         rd_entry;
  cmd_code_t     match_code;
  logic          match_start;
  logic [7:0]    c;
  logic [CW-1:0] cur_dec;
  logic [CW-1:0] cur_inc;
  logic [CW-1:0] cur_edit;
  logic [CW-1:0] len_edit;

  assign in_ready    = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;
  assign c           = in_ch.rx_byte;
  assign cur_dec     = cur_r - CW'(1);
  assign cur_inc     = cur_r + CW'(1);
  assign match_start = accept && (c == CH_CR);

  always_comb begin
    state_nxt        = state_r;
    cur_nxt          = cur_r;
    len_nxt          = len_r;
    scan_idx_nxt     = scan_idx_r;
    step_nxt         = 1'b0;
    step_idx_nxt     = step_idx_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    echo_valid_nxt   = echo_valid_r;
    echo_byte_nxt    = echo_byte_r;
    line_event_nxt   = line_event_r;
    command_code_nxt = command_code_r;
    clr              = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = AW'(cur_r);
    wr_data          = NUL;
    cur_edit         = cur_r;
    len_edit         = len_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (c == CH_CR) begin
            state_nxt    = ST_SCAN;
            scan_idx_nxt = '0;
          end else begin
            out_valid_nxt    = 1'b1;
            echo_valid_nxt   = 1'b0;
            echo_byte_nxt    = NUL;
            line_event_nxt   = EV_NONE;
            command_code_nxt = CMD_INVALID;
            if (c == CH_BS) begin
              echo_valid_nxt = 1'b1;
              if (cur_r != '0) begin
                cur_edit      = cur_dec;
                wr_en         = 1'b1;
                wr_addr       = AW'(cur_dec);
                echo_byte_nxt = c[6:0];
                if (cur_r == len_r) begin
                  len_edit = len_r - CW'(1);
                  wr_data  = NUL;
                end else begin
                  wr_data  = SPACE;
                end
              end else begin
                echo_byte_nxt = BELL;
              end
            end else if (c == CH_RIGHT) begin
              echo_valid_nxt = 1'b1;
              if (cur_r < len_r) begin
                cur_edit      = cur_inc;
                echo_byte_nxt = c[6:0];
              end else begin
                echo_byte_nxt = BELL;
              end
            end else if (c == CH_LEFT) begin
              echo_valid_nxt = 1'b1;
              if (cur_r != '0) begin
                cur_edit      = cur_dec;
                echo_byte_nxt = c[6:0];
              end else begin
                echo_byte_nxt = BELL;
              end
            end else if (c == CH_EOT) begin
              line_event_nxt = EV_EOT;
            end else if (c == CH_CAN) begin
              line_event_nxt = EV_CANCEL;
              clr            = 1'b1;
              cur_edit       = '0;
              len_edit       = '0;
            end else if (c < CH_PRINT_LO) begin
              echo_valid_nxt = 1'b0;
            end else if (c == CH_DEL) begin
              echo_valid_nxt = 1'b1;
              if (len_r == '0 || cur_r == len_r) begin
                echo_byte_nxt = BELL;
              end else begin
                wr_en         = 1'b1;
                echo_byte_nxt = c[6:0];
                if (cur_inc == len_r) begin
                  len_edit = len_r - CW'(1);
                  wr_data  = NUL;
                end else begin
                  wr_data  = SPACE;
                end
              end
            end else if (c < CH_DEL) begin
              echo_valid_nxt = 1'b1;
              if (cur_r < CW'(LINE_CAPACITY)) begin
                wr_en         = 1'b1;
                wr_data       = c[6:0];
                cur_edit      = cur_inc;
                echo_byte_nxt = c[6:0];
              end else begin
                echo_byte_nxt = BELL;
              end
            end else begin
              echo_valid_nxt = 1'b1;
              echo_byte_nxt  = BELL;
            end
            cur_nxt = cur_edit;
            len_nxt = (cur_edit > len_edit) ? cur_edit : len_edit;
          end
        end
      end
      ST_SCAN: begin
        step_nxt     = 1'b1;
        step_idx_nxt = scan_idx_r;
        scan_idx_nxt = scan_idx_r + 3'd1;
        if (scan_idx_r == SCAN_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        out_valid_nxt    = 1'b1;
        echo_valid_nxt   = 1'b0;
        echo_byte_nxt    = NUL;
        line_event_nxt   = EV_COMMAND;
        command_code_nxt = match_code;
        clr              = 1'b1;
        cur_nxt          = '0;
        len_nxt          = '0;
        state_nxt        = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      len_r       <= '0;
      scan_idx_r  <= '0;
      step_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      len_r       <= len_nxt;
      scan_idx_r  <= scan_idx_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    step_idx_r     <= step_idx_nxt;
    echo_valid_r   <= echo_valid_nxt;
    echo_byte_r    <= echo_byte_nxt;
    line_event_r   <= line_event_nxt;
    command_code_r <= command_code_nxt;
  end

  tle_store #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (clr),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (AW'(scan_idx_r)),
    .rd_entry (rd_entry)
  );

  tle_match u_match (
    .clk   (clk),
    .rst_n (rst_n),
    .start (match_start),
    .step  (step_r),
    .idx   (step_idx_r),
    .entry (rd_entry),
    .code  (match_code)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.echo_valid   = echo_valid_r;
  assign out_ch.echo_byte    = echo_byte_r;
  assign out_ch.line_event   = line_event_r;
  assign out_ch.command_code = command_code_r;

endmodule

// ===== design/tle_store.sv =====
`timescale 1ns / 1ps

module tle_store
  import tle_pkg::*;
#(
  parameter int  LINE_CAPACITY = LINE_CAPACITY_DEF,
  localparam int AW = $clog2(LINE_CAPACITY)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  char_t         wr_data,
  input  logic [AW-1:0] rd_addr,
  output char_t         rd_entry
);

  char_t                    mem [LINE_CAPACITY];
  logic [LINE_CAPACITY-1:0] vld_r;
  char_t                    rd_data_r;
  logic                     rd_vld_r;
  logic                     rd_in_range;

  assign rd_in_range = {1'b0, rd_addr} < (AW+1)'(LINE_CAPACITY);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= rd_in_range && vld_r[rd_addr];
    end
  end

  // unwritten entries read as null
  assign rd_entry = rd_vld_r ? rd_data_r : NUL;

endmodule

// ===== design/tle_match.sv =====
`timescale 1ns / 1ps

module tle_match
  import tle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       step,
  input  logic [2:0] idx,
  input  char_t      entry,
  output cmd_code_t  code
);

  logic [NUM_CMDS-1:0] hit_r;
  logic [NUM_CMDS-1:0] hit_nxt;

  always_comb begin
    hit_nxt = hit_r;
    if (start) begin
      hit_nxt = '1;
    end else if (step) begin
      for (int k = 0; k < NUM_CMDS; k++) begin
        if (idx <= CMD_LEN[k] && entry != CMD_TEXT[k][idx]) begin
          hit_nxt[k] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    code = CMD_INVALID;
    for (int k = NUM_CMDS - 1; k >= 0; k--) begin
      if (hit_r[k]) begin
        code = cmd_code_t'(3'(k + 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= '0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

endmodule
